[sv/mwl_pkg.sv]
// Shared types, constants and tables for the month weekday lister.
package mwl_pkg;

    // Request beat: one year and month
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
    } in_beat_t;

    // Result beat: one day of the listed month
    typedef struct packed {
        logic [4:0] day_of_month;
        logic [2:0] weekday;
        logic       last_day;
    } out_beat_t;

    // Work descriptor handed from front to back
    typedef struct packed {
        logic [4:0] month_len;
        logic [2:0] first_weekday;
        logic       gap_month;
    } desc_t;

    // Front sequencer states
    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_SUM,
        F_MOD,
        F_PUSH
    } front_state_t;

    // Month codes
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_MAY = 4'd5;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_JUL = 4'd7;
    localparam logic [3:0] MONTH_AUG = 4'd8;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_OCT = 4'd10;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Calendar reform
    localparam logic [13:0] REFORM_YEAR      = 14'd1582;
    localparam logic [3:0]  REFORM_MONTH     = MONTH_OCT;
    localparam logic [4:0]  LAST_JULIAN_DAY  = 5'd4;
    localparam logic [4:0]  REFORM_FIRST_DAY = 5'd15;

    // Reciprocal constants: y / 100 and s / 7
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [13:0] DIV7_MUL     = 14'd9363;
    localparam int          DIV7_SHIFT   = 16;

    localparam logic [2:0] WEEKDAY_MAX = 3'd6;

    // floor(26 * (m + 1) / 10), January and February as months 13 and 14
    function automatic logic [5:0] month_term(input logic [3:0] month);
        logic [5:0] t;
        unique case (month)
            MONTH_JAN: t = 6'd36;
            MONTH_FEB: t = 6'd39;
            MONTH_MAR: t = 6'd10;
            MONTH_APR: t = 6'd13;
            MONTH_MAY: t = 6'd15;
            MONTH_JUN: t = 6'd18;
            MONTH_JUL: t = 6'd20;
            MONTH_AUG: t = 6'd23;
            MONTH_SEP: t = 6'd26;
            MONTH_OCT: t = 6'd28;
            MONTH_NOV: t = 6'd31;
            MONTH_DEC: t = 6'd33;
            default:   t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

[sv/mwl_front.sv]
// Request front end: validates a year/month and works out length and first weekday.
module mwl_front import mwl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output desc_t    q_desc
);

    front_state_t state_reg, state_next;

    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [13:0] y_reg, y_next;
    logic [7:0]  j_reg, j_next;
    logic [10:0] sum_reg, sum_next;
    logic [8:0]  q_reg, q_next;
    logic [4:0]  len_reg, len_next;
    logic        gap_reg, gap_next;

    logic        req_ok;
    logic [26:0] div100_prod;
    logic [13:0] k_full;
    logic [6:0]  k;
    logic        julian;
    logic        leap;
    logic [10:0] century;
    logic [24:0] div7_prod;
    logic [10:0] r_full;

    // Request is listed only for a nonzero year and a real month
    assign req_ok = (s_data.year != 14'd0) &&
                    (s_data.month >= MONTH_JAN) && (s_data.month <= MONTH_DEC);

    // Zeller shifts January and February into the previous year
    assign y_next = (s_data.month < MONTH_MAR) ? (s_data.year - 14'd1) : s_data.year;

    // Century by reciprocal multiply
    assign div100_prod = 27'(y_reg) * 27'(DIV100_MUL);
    assign j_next      = div100_prod[DIV100_SHIFT +: 8];

    // Year within century
    assign k_full = y_reg - (14'(j_reg) * 14'd100);
    assign k      = k_full[6:0];

    // Day 1 is Julian up to and including the reform month
    assign julian = (year_reg < REFORM_YEAR) ||
                    ((year_reg == REFORM_YEAR) && (month_reg <= REFORM_MONTH));

    // Gregorian century years: k == 99 means the year itself ends in 00,
    // and its century is j + 1
    always_comb begin
        if (year_reg < REFORM_YEAR) begin
            leap = (year_reg[1:0] == 2'd0);
        end else begin
            leap = (year_reg[1:0] == 2'd0) && ((k != 7'd99) || (j_reg[1:0] == 2'b11));
        end
    end

    always_comb begin
        case (month_reg) inside
            MONTH_FEB:                               len_next = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len_next = 5'd30;
            default:                                 len_next = 5'd31;
        endcase
    end

    assign gap_next = (year_reg == REFORM_YEAR) && (month_reg == REFORM_MONTH);

    // Weekday sum for day 1
    assign century  = julian ? (11'd5 + 11'(j_reg) * 11'd6)
                             : (11'(j_reg >> 2) + 11'(j_reg) * 11'd5);
    assign sum_next = 11'd1 + 11'(month_term(month_reg)) + 11'(k) + 11'(k >> 2) + century;

    // Mod 7 by reciprocal multiply and one subtract
    assign div7_prod = 25'(sum_reg) * 25'(DIV7_MUL);
    assign q_next    = div7_prod[DIV7_SHIFT +: 9];
    assign r_full    = sum_reg - (11'(q_reg) * 11'd7);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (s_valid && req_ok) state_next = F_DIV;
            F_DIV:  state_next = F_SUM;
            F_SUM:  state_next = F_MOD;
            F_MOD:  state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready = 1'b0;
        q_push  = 1'b0;
        unique case (state_reg)
            F_IDLE:  s_ready = 1'b1;
            F_PUSH:  q_push  = !q_full;
            default: begin
                s_ready = 1'b0;
                q_push  = 1'b0;
            end
        endcase
    end

    assign q_desc.month_len     = len_reg;
    assign q_desc.first_weekday = r_full[2:0];
    assign q_desc.gap_month     = gap_reg;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_valid) begin
            year_reg  <= s_data.year;
            month_reg <= s_data.month;
            y_reg     <= y_next;
        end
        if (state_reg == F_DIV) begin
            j_reg <= j_next;
        end
        if (state_reg == F_SUM) begin
            sum_reg <= sum_next;
            len_reg <= len_next;
            gap_reg <= gap_next;
        end
        if (state_reg == F_MOD) begin
            q_reg <= q_next;
        end
    end

endmodule

[sv/mwl_desc_fifo.sv]
// Short descriptor queue between the front end and the day generator.
module mwl_desc_fifo import mwl_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output desc_t pop_desc
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t         mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_desc  = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[sv/mwl_back.sv]
// Day generator: walks one descriptor's days into the result register.
module mwl_back import mwl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_not_empty,
    input  desc_t     q_desc,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic       valid_reg, valid_next;
    logic [4:0] day_reg, day_next;
    logic [2:0] wd_reg, wd_next;
    logic       last_reg, last_next;
    logic [4:0] len_reg, len_next;
    logic       gap_reg, gap_next;
    logic [4:0] day_step;

    // Load a new month when idle or when its final beat leaves
    assign q_pop = q_not_empty && (!valid_reg || (m_ready && last_reg));

    // Skip the missing October days after the last Julian day
    assign day_step = (gap_reg && (day_reg == LAST_JULIAN_DAY)) ? REFORM_FIRST_DAY
                                                                : day_reg + 5'd1;

    always_comb begin
        valid_next = valid_reg;
        day_next   = day_reg;
        wd_next    = wd_reg;
        last_next  = last_reg;
        len_next   = len_reg;
        gap_next   = gap_reg;
        if (q_pop) begin
            valid_next = 1'b1;
            day_next   = 5'd1;
            wd_next    = q_desc.first_weekday;
            last_next  = (q_desc.month_len == 5'd1);
            len_next   = q_desc.month_len;
            gap_next   = q_desc.gap_month;
        end else if (valid_reg && m_ready) begin
            if (last_reg) begin
                valid_next = 1'b0;
            end else begin
                day_next  = day_step;
                wd_next   = (wd_reg == WEEKDAY_MAX) ? 3'd0 : wd_reg + 3'd1;
                last_next = (day_step == len_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        day_reg  <= day_next;
        wd_reg   <= wd_next;
        last_reg <= last_next;
        len_reg  <= len_next;
        gap_reg  <= gap_next;
    end

    assign m_valid             = valid_reg;
    assign m_data.day_of_month = day_reg;
    assign m_data.weekday      = wd_reg;
    assign m_data.last_day     = last_reg;

`ifndef SYNTHESIS
    // Weekday stays in range while a beat is offered
    a_wd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (wd_reg <= WEEKDAY_MAX))
        else $error("weekday out of range");

    // A taken beat that is not the last is followed by the next day
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && m_ready && !last_reg) |=> (valid_reg && (day_reg > $past(day_reg))))
        else $error("day did not advance");

    // Missing reform days never appear
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && gap_reg) |-> !((day_reg > LAST_JULIAN_DAY) &&
                                     (day_reg < REFORM_FIRST_DAY)))
        else $error("skipped day emitted");

    // The final beat carries the month length
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && last_reg) |-> (day_reg == len_reg))
        else $error("last beat on wrong day");
`endif

endmodule

[sv/month_weekday_lister_top.sv]
// Top level of the month weekday lister: front end, descriptor queue, day generator.
//
// Channel  Dir  Handshake          Beat
// s_       in   s_valid/s_ready    in_beat_t  {year, month}
// m_       out  m_valid/m_ready    out_beat_t {day_of_month, weekday, last_day}
//
// A request passes through the front-end steps accept, century multiply, sum, mod-7
// multiply and queue push, the push waiting while the queue is full; an invalid year or
// month is dropped in its accept cycle. The day generator emits one beat per cycle
// while m_ready is high, one beat per listed day (28 to 31, 21 for October 1582).
// The queue holds QUEUE_DEPTH months so the front end runs ahead of the output.
// Reset is synchronous on aresetn, active low; no clearing pass is needed.
module month_weekday_lister_top import mwl_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic  q_full;
    logic  q_push;
    desc_t q_push_desc;
    logic  q_pop;
    logic  q_not_empty;
    desc_t q_pop_desc;

    mwl_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_desc  (q_push_desc)
    );

    mwl_desc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_desc  (q_pop_desc)
    );

    mwl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_desc      (q_pop_desc),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[verif/month_weekday_lister_top_tb.sv]
// Testbench for month_weekday_lister_top: directed table, random months, day-by-day checks.
`timescale 1ns / 1ps

module month_weekday_lister_top_tb import mwl_pkg::*;;

    // Month codes outside the calendar
    localparam logic [3:0] MONTH_NONE     = 4'd0;
    localparam logic [3:0] MONTH_OVER     = 4'd13;
    localparam logic [3:0] MONTH_ALL_ONES = 4'd15;

    // Weekday codes
    localparam logic [2:0] WD_SAT = 3'd0;
    localparam logic [2:0] WD_SUN = 3'd1;
    localparam logic [2:0] WD_MON = 3'd2;
    localparam logic [2:0] WD_TUE = 3'd3;
    localparam logic [2:0] WD_WED = 3'd4;
    localparam logic [2:0] WD_THU = 3'd5;
    localparam logic [2:0] WD_FRI = 3'd6;

    localparam logic [13:0] YEAR_MAX_FIELD = 14'd16383;
    localparam int RANDOM_MONTHS = 210;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int MAX_PRINTED   = 50;

    // One directed request; typed rows carry their own day count and first weekday
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic        typed;
        logic [5:0]  n_days;
        logic [2:0]  first_wd;
    } dir_row_t;

    localparam int NUM_DIRECTED = 24;
    localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // dropped requests: year zero, months out of range
        '{14'd0,          MONTH_JAN,      1'b1, 6'd0,  WD_SAT},
        '{14'd2000,       MONTH_NONE,     1'b1, 6'd0,  WD_SAT},
        '{14'd2000,       MONTH_OVER,     1'b1, 6'd0,  WD_SAT},
        '{YEAR_MAX_FIELD, MONTH_ALL_ONES, 1'b1, 6'd0,  WD_SAT},
        // well-known first days
        '{14'd1,          MONTH_JAN,      1'b1, 6'd31, WD_SAT},
        '{14'd2000,       MONTH_JAN,      1'b1, 6'd31, WD_SAT},
        '{14'd2000,       MONTH_FEB,      1'b1, 6'd29, WD_TUE},
        '{14'd1900,       MONTH_FEB,      1'b1, 6'd28, WD_THU},
        '{14'd9999,       MONTH_DEC,      1'b1, 6'd31, WD_WED},
        // reform months, Julian leap, wrap to year zero, years past 9999
        '{REFORM_YEAR,    MONTH_OCT,      1'b0, 6'd0,  WD_SAT},
        '{REFORM_YEAR,    MONTH_SEP,      1'b0, 6'd0,  WD_SAT},
        '{REFORM_YEAR,    MONTH_NOV,      1'b0, 6'd0,  WD_SAT},
        '{14'd1500,       MONTH_FEB,      1'b0, 6'd0,  WD_SAT},
        '{14'd1,          MONTH_FEB,      1'b0, 6'd0,  WD_SAT},
        '{YEAR_MAX_FIELD, MONTH_DEC,      1'b0, 6'd0,  WD_SAT},
        '{14'd10000,      MONTH_FEB,      1'b0, 6'd0,  WD_SAT},
        // remaining month lengths
        '{14'd2023,       MONTH_MAR,      1'b0, 6'd0,  WD_SAT},
        '{14'd2024,       MONTH_APR,      1'b0, 6'd0,  WD_SAT},
        '{14'd2024,       MONTH_MAY,      1'b0, 6'd0,  WD_SAT},
        '{14'd2024,       MONTH_JUN,      1'b0, 6'd0,  WD_SAT},
        '{14'd2024,       MONTH_JUL,      1'b0, 6'd0,  WD_SAT},
        '{14'd2024,       MONTH_AUG,      1'b0, 6'd0,  WD_SAT},
        '{14'd1583,       MONTH_JAN,      1'b0, 6'd0,  WD_SAT},
        '{14'd8191,       MONTH_FEB,      1'b0, 6'd0,  WD_SAT}
    };

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    out_beat_t expected_days[$];
    out_beat_t want_day;
    int        mismatch_count = 0;
    int        send_idle_pct  = 34;
    int        recv_idle_pct  = 45;
    int        stall_cycles   = 0;

    month_weekday_lister_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // ---------------- calendar predictor ----------------

    function automatic bit leap_year(input int unsigned yr);
        if (yr < REFORM_YEAR) begin
            return (yr % 4) == 0;
        end
        if ((yr % 4) != 0) begin
            return 1'b0;
        end
        if ((yr % 100) != 0) begin
            return 1'b1;
        end
        return (yr % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned yr,
                                                  input logic [3:0] mo);
        case (mo)
            MONTH_FEB: begin
                return leap_year(yr) ? 29 : 28;
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    function automatic bit julian_date(input int unsigned yr, input logic [3:0] mo,
                                       input int unsigned day);
        if (yr != REFORM_YEAR) begin
            return yr < REFORM_YEAR;
        end
        if (mo < REFORM_MONTH) begin
            return 1'b1;
        end
        return mo == REFORM_MONTH && day < REFORM_FIRST_DAY;
    endfunction

    // Zeller: Jan/Feb count as months 13/14 of the year before
    function automatic logic [2:0] weekday_of(input int unsigned yr, input logic [3:0] mo,
                                              input int unsigned day);
        int unsigned m, y, k, j, sum;
        m = mo;
        y = yr;
        if (mo < MONTH_MAR) begin
            m = mo + 12;
            y = yr - 1;
        end
        k = y % 100;
        j = y / 100;
        sum = day + (26 * m + 26) / 10 + k + k / 4;
        if (julian_date(yr, mo, day)) begin
            sum += 5 + 6 * j;
        end else begin
            sum += j / 4 + 5 * j;
        end
        return 3'(sum % 7);
    endfunction

    // Queue every day the block should list for one request
    task automatic predict_month(input in_beat_t req);
        int unsigned len;
        bit          gap;
        out_beat_t   beat;
        if (req.year == 0 || req.month < MONTH_JAN || req.month > MONTH_DEC) begin
            return;
        end
        len = days_in_month(req.year, req.month);
        gap = (req.year == REFORM_YEAR) && (req.month == REFORM_MONTH);
        for (int unsigned day = 1; day <= len; day++) begin
            if (gap && day > LAST_JULIAN_DAY && day < REFORM_FIRST_DAY) begin
                continue;
            end
            beat.day_of_month = 5'(day);
            beat.weekday      = weekday_of(req.year, req.month, day);
            beat.last_day     = (day == len);
            expected_days.push_back(beat);
        end
    endtask

    // Typed rows: plain month, weekdays rotate from the given first day
    task automatic push_typed_month(input dir_row_t row);
        out_beat_t beat;
        for (int d = 1; d <= row.n_days; d++) begin
            beat.day_of_month = 5'(d);
            beat.weekday      = 3'((row.first_wd + d - 1) % 7);
            beat.last_day     = (d == row.n_days);
            expected_days.push_back(beat);
        end
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Result side: compare each accepted beat, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_days.size() == 0) begin
                report_mismatch($sformatf("unexpected beat day %0d weekday %0d last %0b",
                                          m_data.day_of_month, m_data.weekday,
                                          m_data.last_day));
            end else begin
                want_day = expected_days.pop_front();
                if (m_data.day_of_month !== want_day.day_of_month) begin
                    report_mismatch($sformatf("day_of_month %0d, want %0d",
                                              m_data.day_of_month, want_day.day_of_month));
                end
                if (m_data.weekday !== want_day.weekday) begin
                    report_mismatch($sformatf("day %0d weekday %0d, want %0d",
                                              want_day.day_of_month, m_data.weekday,
                                              want_day.weekday));
                end
                if (m_data.last_day !== want_day.last_day) begin
                    report_mismatch($sformatf("day %0d last_day %0b, want %0b",
                                              want_day.day_of_month, m_data.last_day,
                                              want_day.last_day));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------

    // Present one request, with a random idle gap ahead of it; returns on acceptance
    task automatic send_request(input in_beat_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly valid months, weighted toward the reform and years past 9999
    function automatic in_beat_t random_request();
        in_beat_t req;
        int       pick;
        pick      = $urandom_range(99);
        req.month = 4'($urandom_range(MONTH_DEC, MONTH_JAN));
        if (pick < 55) begin
            req.year = 14'($urandom_range(9999, 1));
        end else if (pick < 70) begin
            req.year = 14'($urandom_range(1610, 1570));
        end else if (pick < 76) begin
            req.year  = REFORM_YEAR;
            req.month = 4'($urandom_range(MONTH_NOV, MONTH_SEP));
        end else if (pick < 88) begin
            req.year = 14'($urandom_range(YEAR_MAX_FIELD, 10000));
        end else if (pick < 96) begin
            req.year  = 14'($urandom_range(YEAR_MAX_FIELD));
            req.month = ($urandom_range(3) == 0) ? MONTH_NONE
                                                 : 4'(MONTH_OVER + $urandom_range(2));
        end else begin
            req.year = 14'd0;
        end
        return req;
    endfunction

    function automatic bit lists_days(input in_beat_t req);
        return req.year != 0 && req.month >= MONTH_JAN && req.month <= MONTH_DEC;
    endfunction

    initial begin
        in_beat_t req;
        int       listed;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            req.year  = DIRECTED_ROWS[i].year;
            req.month = DIRECTED_ROWS[i].month;
            send_request(req);
            if (DIRECTED_ROWS[i].typed) begin
                push_typed_month(DIRECTED_ROWS[i]);
            end else begin
                predict_month(req);
            end
        end

        // Hold the sender until the block has emptied
        s_valid <= 1'b0;
        while (expected_days.size() != 0) @(posedge aclk);

        // Random months across three idling phases
        listed = 0;
        while (listed < RANDOM_MONTHS) begin
            if (listed < RANDOM_MONTHS / 3) begin
                send_idle_pct = 34;
                recv_idle_pct = 45;
            end else if (listed < 2 * RANDOM_MONTHS / 3) begin
                send_idle_pct = 45;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            req = random_request();
            send_request(req);
            predict_month(req);
            if (lists_days(req)) begin
                listed++;
            end
        end
        s_valid <= 1'b0;

        // Drain, then give dropped requests time to show anything stray
        while (expected_days.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
